FILE: sv/frta_pkg.sv
// ----------------------------------------------------------------------------
// frta_pkg
// Types, codes and page arithmetic shared by the free range table allocator.
// ----------------------------------------------------------------------------
package frta_pkg;

   localparam int PAGE_BITS = 12;
   localparam int PAGE_W    = 32 - PAGE_BITS;

   localparam logic [33:0]       PAGE_MASK  = (34'd1 << PAGE_BITS) - 34'd1;
   localparam logic [PAGE_W+1:0] PAGE_LIMIT = (PAGE_W+2)'(1) << PAGE_W;

   // item kinds
   localparam logic [1:0] KIND_ADD     = 2'd0;
   localparam logic [1:0] KIND_RESERVE = 2'd1;
   localparam logic [1:0] KIND_ALLOC   = 2'd2;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // configuration register indexes
   localparam logic CSR_WINDOW_START = 1'b0;
   localparam logic CSR_WINDOW_END   = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_RD,
      S_P1,
      S_P2,
      S_SPAN,
      S_END,
      S_FIN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] base;
      logic [31:0] size;
      logic [4:0]  align_log2;
   } req_type;

   typedef struct packed {
      logic [31:0]     address;
      logic [1:0]      status;
      logic [PAGE_W:0] free_pages;
   } rsp_type;

   typedef struct packed {
      logic [PAGE_W-1:0] start_page;
      logic [PAGE_W:0]   page_count;
   } entry_type;

   typedef struct packed {
      logic [PAGE_W:0] first;
      logic [PAGE_W:0] last;
   } span_type;

   // widen a byte range to whole pages, end saturated at the top of the space
   function automatic span_type page_span(logic [31:0] base, logic [31:0] size);
      logic [32:0] end_v;
      logic [33:0] rnd;
      span_type    sp;
      end_v    = {1'b0, base} + {1'b0, size};
      rnd      = {1'b0, end_v} + PAGE_MASK;
      sp.first = {1'b0, base[31:PAGE_BITS]};
      if (rnd[33:PAGE_BITS] > PAGE_LIMIT) begin
         sp.last = PAGE_LIMIT[PAGE_W:0];
      end else begin
         sp.last = rnd[PAGE_BITS+PAGE_W:PAGE_BITS];
      end
      return sp;
   endfunction

endpackage

FILE: sv/frta_ram.sv
// ----------------------------------------------------------------------------
// frta_ram
// One bank of the range table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module frta_ram #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  frta_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output frta_pkg::entry_type rd_data
);

   frta_pkg::entry_type mem [DEPTH];
   frta_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/free_range_table_allocator.sv
// ----------------------------------------------------------------------------
// free_range_table_allocator
// Sorted table of disjoint free page ranges with add, reserve and allocate.
// ----------------------------------------------------------------------------
// One item at a time. Each item not settled at set-up walks the table held
// in one of two banks, reading one entry per read cycle and writing the
// rebuilt table into the other bank; a successful item flips the banks, a
// failed one leaves the old bank in place, so a full or missed item never
// disturbs the table. In an add or reserve pass each entry is read, then
// consumed, with one more step when it gives two pieces (a reserve split, or
// an add placing the new range ahead of it); set-up comes before the pass
// and the finish after it. Allocate first runs a search pass in which each
// entry examined is read, clipped to the window and tested for fit, then
// widens the chosen candidate and runs a full reserve pass. The single read
// port of the source bank is why each entry needs its own read step.
// Reads and writes always go to different banks, so no forwarding is needed.
// The result waits in an output register and a new item may be taken while
// it does.
// ----------------------------------------------------------------------------
module free_range_table_allocator #(
   parameter int MAX_REGIONS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  frta_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output frta_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);

   localparam int PW    = frta_pkg::PAGE_W;
   localparam int PB    = frta_pkg::PAGE_BITS;
   localparam int IDX_W = $clog2(MAX_REGIONS);
   localparam int CNT_W = $clog2(MAX_REGIONS + 2);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_REGIONS);
   localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_REGIONS + 1);

   frta_pkg::state_type state_ff, state_in;

   logic [31:0] win_start_ff, win_end_ff;

   // item held while it is worked on
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] base_ff, base_in;
   logic [31:0] size_ff, size_in;
   logic [4:0]  lg_ff, lg_in;

   // pass state
   logic [PW:0]      b_ff, b_in, e_ff, e_in;
   logic             placed_ff, placed_in, hit_ff, hit_in, scan_ff, scan_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [PW:0]      sum_ff, sum_in;
   logic             pend_ff, pend_in;
   logic [PW:0]      pend_s_ff, pend_s_in, pend_t_ff, pend_t_in;
   logic [31:0]      rb_ff, rb_in, re_ff, re_in, cand_ff, cand_in;

   // table state
   logic             bank_ff, bank_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PW:0]      total_ff, total_in;

   // result
   logic [31:0]       res_addr_ff, res_addr_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   frta_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // memory side
   logic                rd_en, wr_en;
   logic [IDX_W-1:0]    rd_addr, wr_addr;
   frta_pkg::entry_type wr_entry, rd_data0, rd_data1, rd_entry;

   // push of one piece into the rebuilt table
   logic        push_en;
   logic [PW:0] push_s, push_t;

   // per entry values
   logic [PW:0]         s_x, t_x;
   logic [31:0]         lo_b, rb_v, re_v;
   logic [32:0]         hi_b, hi_c;
   logic [32:0]         amask, cand_v;
   logic                fit;
   frta_pkg::span_type  sp;
   frta_pkg::span_type  sp_cut;
   logic                cut_mode;

   frta_ram #(.DEPTH(MAX_REGIONS), .ADDR_W(IDX_W)) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_en & bank_ff),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en & ~bank_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data0)
   );

   frta_ram #(.DEPTH(MAX_REGIONS), .ADDR_W(IDX_W)) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_en & ~bank_ff),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en & bank_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data1)
   );

   assign rd_entry  = bank_ff ? rd_data1 : rd_data0;
   assign req_stall = (state_ff != frta_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // entry bounds and window clipping
   always_comb begin
      s_x  = {1'b0, rd_entry.start_page};
      t_x  = s_x + rd_entry.page_count;
      lo_b = {rd_entry.start_page, PB'(0)};
      hi_b = {t_x, PB'(0)};
      rb_v = (lo_b < win_start_ff) ? win_start_ff : lo_b;
      rb_v = (rb_v > win_end_ff) ? win_end_ff : rb_v;
      hi_c = (hi_b < {1'b0, win_start_ff}) ? {1'b0, win_start_ff} : hi_b;
      re_v = (hi_c > {1'b0, win_end_ff}) ? win_end_ff : hi_c[31:0];
      amask  = (33'd1 << lg_ff) - 33'd1;
      cand_v = ({1'b0, rb_ff} + amask) & ~amask;
      fit    = (cand_v < {1'b0, re_ff}) && (({1'b0, re_ff} - cand_v) >= {1'b0, size_ff});
      sp     = frta_pkg::page_span(base_ff, size_ff);
      sp_cut = frta_pkg::page_span(cand_ff, size_ff);
      cut_mode = (kind_ff != frta_pkg::KIND_ADD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frta_pkg::S_IDLE;
         win_start_ff <= 32'd0;
         win_end_ff   <= 32'd1048576;
         bank_ff      <= 1'b0;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         if (csr_we) begin
            if (csr_index == frta_pkg::CSR_WINDOW_START) begin
               win_start_ff <= csr_wdata;
            end else begin
               win_end_ff <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      base_ff       <= base_in;
      size_ff       <= size_in;
      lg_ff         <= lg_in;
      b_ff          <= b_in;
      e_ff          <= e_in;
      placed_ff     <= placed_in;
      hit_ff        <= hit_in;
      scan_ff       <= scan_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      sum_ff        <= sum_in;
      pend_s_ff     <= pend_s_in;
      pend_t_ff     <= pend_t_in;
      rb_ff         <= rb_in;
      re_ff         <= re_in;
      cand_ff       <= cand_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      base_in       = base_ff;
      size_in       = size_ff;
      lg_in         = lg_ff;
      b_in          = b_ff;
      e_in          = e_ff;
      placed_in     = placed_ff;
      hit_in        = hit_ff;
      scan_in       = scan_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      sum_in        = sum_ff;
      pend_in       = pend_ff;
      pend_s_in     = pend_s_ff;
      pend_t_in     = pend_t_ff;
      rb_in         = rb_ff;
      re_in         = re_ff;
      cand_in       = cand_ff;
      bank_in       = bank_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rd_en         = 1'b0;
      rd_addr       = i_ff[IDX_W-1:0];
      push_en       = 1'b0;
      push_s        = s_x;
      push_t        = t_x;

      // drop the result once it has been taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         frta_pkg::S_IDLE: begin
            if (req_valid) begin
               kind_in  = req_data.kind;
               base_in  = req_data.base;
               size_in  = req_data.size;
               lg_in    = req_data.align_log2;
               state_in = frta_pkg::S_PREP;
            end
         end
         frta_pkg::S_PREP: begin
            res_addr_in = 32'd0;
            i_in        = '0;
            j_in        = '0;
            sum_in      = '0;
            placed_in   = 1'b0;
            hit_in      = 1'b0;
            pend_in     = 1'b0;
            scan_in     = 1'b0;
            b_in        = sp.first;
            e_in        = sp.last;
            case (kind_ff)
               frta_pkg::KIND_ADD: begin
                  if (sp.first >= sp.last) begin
                     res_status_in = frta_pkg::ST_OK;
                     state_in      = frta_pkg::S_DONE;
                  end else begin
                     state_in = frta_pkg::S_RD;
                  end
               end
               frta_pkg::KIND_RESERVE: begin
                  if (sp.first >= sp.last) begin
                     res_status_in = frta_pkg::ST_MISS;
                     state_in      = frta_pkg::S_DONE;
                  end else begin
                     state_in = frta_pkg::S_RD;
                  end
               end
               frta_pkg::KIND_ALLOC: begin
                  if (size_ff == 32'd0) begin
                     res_status_in = frta_pkg::ST_MISS;
                     state_in      = frta_pkg::S_DONE;
                  end else begin
                     scan_in  = 1'b1;
                     state_in = frta_pkg::S_RD;
                  end
               end
               default: begin
                  res_status_in = frta_pkg::ST_MISS;
                  state_in      = frta_pkg::S_DONE;
               end
            endcase
         end
         frta_pkg::S_RD: begin
            if (i_ff == count_ff) begin
               state_in = scan_ff ? frta_pkg::S_FIN : frta_pkg::S_END;
            end else begin
               rd_en    = 1'b1;
               state_in = frta_pkg::S_P1;
            end
         end
         frta_pkg::S_P1: begin
            if (scan_ff) begin
               rb_in    = rb_v;
               re_in    = re_v;
               state_in = frta_pkg::S_P2;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = frta_pkg::S_RD;
               if (!cut_mode) begin
                  if (t_x < b_ff) begin
                     push_en = 1'b1;
                  end else if (s_x > e_ff) begin
                     push_en = 1'b1;
                     if (!placed_ff) begin
                        // new range goes ahead of this entry
                        push_s    = b_ff;
                        push_t    = e_ff;
                        placed_in = 1'b1;
                        pend_in   = 1'b1;
                        pend_s_in = s_x;
                        pend_t_in = t_x;
                        state_in  = frta_pkg::S_P2;
                     end
                  end else begin
                     // overlapping or touching: absorb into the new range
                     if (s_x < b_ff) b_in = s_x;
                     if (t_x > e_ff) e_in = t_x;
                  end
               end else begin
                  if (t_x <= b_ff || s_x >= e_ff) begin
                     push_en = 1'b1;
                  end else begin
                     hit_in = 1'b1;
                     if (s_x < b_ff) begin
                        push_en = 1'b1;
                        push_t  = b_ff;
                        if (t_x > e_ff) begin
                           pend_in   = 1'b1;
                           pend_s_in = e_ff;
                           pend_t_in = t_x;
                           state_in  = frta_pkg::S_P2;
                        end
                     end else if (t_x > e_ff) begin
                        push_en = 1'b1;
                        push_s  = e_ff;
                     end
                  end
               end
            end
         end
         frta_pkg::S_P2: begin
            if (scan_ff) begin
               if (fit) begin
                  cand_in  = cand_v[31:0];
                  state_in = frta_pkg::S_SPAN;
               end else begin
                  i_in     = i_ff + CNT_W'(1);
                  state_in = frta_pkg::S_RD;
               end
            end else begin
               push_en  = pend_ff;
               push_s   = pend_s_ff;
               push_t   = pend_t_ff;
               pend_in  = 1'b0;
               state_in = frta_pkg::S_RD;
            end
         end
         frta_pkg::S_SPAN: begin
            // reserve the pages under the chosen candidate
            b_in     = sp_cut.first;
            e_in     = sp_cut.last;
            scan_in  = 1'b0;
            i_in     = '0;
            j_in     = '0;
            sum_in   = '0;
            hit_in   = 1'b0;
            pend_in  = 1'b0;
            state_in = frta_pkg::S_RD;
         end
         frta_pkg::S_END: begin
            if (!cut_mode && !placed_ff) begin
               push_en = 1'b1;
               push_s  = b_ff;
               push_t  = e_ff;
            end
            state_in = frta_pkg::S_FIN;
         end
         frta_pkg::S_FIN: begin
            res_addr_in = 32'd0;
            if (scan_ff) begin
               res_status_in = frta_pkg::ST_MISS;
            end else if (j_ff == CNT_OVER) begin
               res_status_in = frta_pkg::ST_FULL;
            end else if (cut_mode && !hit_ff) begin
               res_status_in = frta_pkg::ST_MISS;
            end else begin
               res_status_in = frta_pkg::ST_OK;
               bank_in       = ~bank_ff;
               count_in      = j_ff;
               total_in      = sum_ff;
               if (kind_ff == frta_pkg::KIND_RESERVE) begin
                  res_addr_in = {b_ff[PW-1:0], PB'(0)};
               end else if (kind_ff == frta_pkg::KIND_ALLOC) begin
                  res_addr_in = cand_ff;
               end
            end
            state_in = frta_pkg::S_DONE;
         end
         frta_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.address    = res_addr_ff;
               rsp_data_in.status     = res_status_ff;
               rsp_data_in.free_pages = total_ff;
               state_in               = frta_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = frta_pkg::S_IDLE;
         end
      endcase

      // append one piece to the rebuilt table; count past the end saturates
      wr_en    = push_en && (j_ff < CNT_MAX);
      wr_addr  = j_ff[IDX_W-1:0];
      wr_entry.start_page = push_s[PW-1:0];
      wr_entry.page_count = push_t - push_s;
      if (push_en) begin
         sum_in = sum_ff + (push_t - push_s);
         if (j_ff != CNT_OVER) begin
            j_in = j_ff + CNT_W'(1);
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("table count beyond capacity");

   a_empty_total: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (total_ff == '0))
      else $error("empty table holds pages");

   a_filled_total: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (total_ff != '0))
      else $error("filled table holds no pages");

   a_take_prep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == frta_pkg::S_PREP))
      else $error("transfer not followed by set-up");
`endif

endmodule
